/* rtl/cae_pkg.sv */
// Shared types, register codes and constants of the complementary attitude estimator.
package cae_pkg;

  // Payload types of the channels.
  typedef logic signed [10:0] sample_t;
  typedef logic [15:0]        ticks_t;
  typedef logic signed [15:0] angle_t;
  typedef logic [1:0]         cfg_index_t;
  typedef logic [7:0]         cfg_data_t;

  // Configuration register indexes and their reset values.
  localparam cfg_index_t REG_LPF_DIVISOR = 2'd0;
  localparam cfg_index_t REG_CF_WEIGHT   = 2'd1;
  localparam logic [7:0] LPF_DIVISOR_RST = 8'd8;
  localparam logic [6:0] CF_WEIGHT_RST   = 7'd30;

  // Timer ticks per second of the period input.
  localparam logic [19:0] TICK_DIV = 20'd1000000;

  // Roll wrap thresholds and targets in degrees.
  localparam int WRAP_HIGH   = 185;
  localparam int WRAP_LOW    = -185;
  localparam int WRAP_TO_NEG = -175;
  localparam int WRAP_TO_POS = 175;

  // Squared magnitude window for trusting the accelerometers.
  localparam logic [21:0] MAG_LOW  = 22'd11289;
  localparam logic [21:0] MAG_HIGH = 22'd20664;

  // Angle output constants in 0.01 degree.
  localparam angle_t      HALF_TURN_CD    = 16'sd18000;
  localparam logic [13:0] QUARTER_TURN_CD = 14'd9000;
  localparam logic [5:0]  GYRO_OUT_SCALE  = 6'd50;
  localparam int          SAT_POS_MAG     = 32767;
  localparam int          SAT_NEG_MAG     = 32768;

  // Square root and CORDIC constants.
  localparam int          SQRT_STEPS     = 32;
  localparam int          SQ_SHIFT       = 40;
  localparam int          ANGLE_FRAC     = 20;
  localparam int          CORDIC_STEPS   = 24;
  localparam logic [30:0] HALF_PI_Q30    = 31'd1686629713;
  localparam logic [28:0] CD_PER_RAD_Q16 = 29'd375493621;

  localparam logic [29:0] ATAN_Q30 [CORDIC_STEPS] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
    30'd33543515,  30'd16775850,  30'd8388437,   30'd4194282,   30'd2097149,
    30'd1048575,   30'd524287,    30'd262143,    30'd131071,    30'd65535,
    30'd32767,     30'd16383,     30'd8191,      30'd4095,      30'd2047,
    30'd1023,      30'd511,       30'd255,       30'd127
  };

endpackage

/* rtl/cae_if.sv */
// Channel interfaces of the estimator: sensor items, attitude results and register writes.
interface cae_in_if import cae_pkg::*; ();
  logic    valid;
  logic    ready;
  logic    restart;
  ticks_t  period_ticks;
  sample_t accel_roll;
  sample_t accel_pitch;
  sample_t accel_vertical;
  sample_t gyro_roll;
  sample_t gyro_pitch;

  modport source (output valid, restart, period_ticks, accel_roll, accel_pitch,
                  accel_vertical, gyro_roll, gyro_pitch, input ready);
  modport sink (input valid, restart, period_ticks, accel_roll, accel_pitch,
                accel_vertical, gyro_roll, gyro_pitch, output ready);
endinterface

interface cae_out_if import cae_pkg::*; ();
  logic   valid;
  logic   ready;
  angle_t roll_angle;
  angle_t pitch_angle;
  logic   accel_trusted;

  modport source (output valid, roll_angle, pitch_angle, accel_trusted, input ready);
  modport sink (input valid, roll_angle, pitch_angle, accel_trusted, output ready);
endinterface

interface cae_cfg_if import cae_pkg::*; ();
  logic       valid;
  logic       ready;
  cfg_index_t index;
  cfg_data_t  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/complementary_attitude_estimator.sv */
// Top level of the complementary-filter attitude estimator (roll and pitch).
// The block takes one sensor item at a time and returns one attitude item for it. All
// divisions share one restoring divider that retires one quotient bit per cycle over
// DIVW = max(58, FRAC_BITS + 26) bits. An item without accelerometer fusion runs four
// divisions. A fused item runs six divisions plus, for each of the two angles, a
// 32-step integer square root and a 24-step CORDIC. A finished item waits in the
// output register, so the next item is accepted while the previous one is unread.
// Register writes are taken in any cycle and should only be issued while the block is idle.
module complementary_attitude_estimator import cae_pkg::*; #(
  parameter int FRAC_BITS = 32
) (
  input logic       clk,
  input logic       rst_n,
  cae_in_if.sink    in_chan,
  cae_out_if.source out_chan,
  cae_cfg_if.sink   cfg_chan
);

  // Widths of the state, the divider and the CORDIC datapath.
  localparam int ST_W  = 48;
  localparam int DIVW  = (FRAC_BITS + 26 > 58) ? FRAC_BITS + 26 : 58;
  localparam int NUM_W = DIVW + 1;
  localparam int SUM_W = DIVW + 2;
  localparam int DVR_W = 20;
  localparam int CNT_W = $clog2(DIVW);
  localparam int DOWN  = (FRAC_BITS >= ANGLE_FRAC) ? FRAC_BITS - ANGLE_FRAC : 0;
  localparam int UP    = (FRAC_BITS < ANGLE_FRAC) ? ANGLE_FRAC - FRAC_BITS : 0;
  localparam int AW    = ST_W + UP;
  localparam int CW    = AW + 3;

  localparam logic signed [ST_W-1:0] ST_MAX = {1'b0, {(ST_W-1){1'b1}}};
  localparam logic signed [ST_W-1:0] ST_MIN = {1'b1, {(ST_W-1){1'b0}}};

  localparam logic signed [63:0] WRAP_HI_FIX  = 64'(WRAP_HIGH) <<< FRAC_BITS;
  localparam logic signed [63:0] WRAP_LO_FIX  = 64'(WRAP_LOW) <<< FRAC_BITS;
  localparam logic signed [63:0] WRAP_NEG_FIX = 64'(WRAP_TO_NEG) <<< FRAC_BITS;
  localparam logic signed [63:0] WRAP_POS_FIX = 64'(WRAP_TO_POS) <<< FRAC_BITS;

  typedef enum logic [13:0] {
    S_IDLE     = 14'h0001,
    S_SQUARE   = 14'h0002,
    S_MUL      = 14'h0004,
    S_PREP     = 14'h0008,
    S_DIV      = 14'h0010,
    S_WB       = 14'h0020,
    S_WRAP     = 14'h0040,
    S_FLIP     = 14'h0080,
    S_ANG_INIT = 14'h0100,
    S_SQRT     = 14'h0200,
    S_CORDIC   = 14'h0400,
    S_ANGLE    = 14'h0800,
    S_GYRO_OUT = 14'h1000,
    S_DONE     = 14'h2000
  } state_t;

  typedef enum logic [2:0] {
    JOB_LPF_ROLL,
    JOB_LPF_PITCH,
    JOB_GYRO_ROLL,
    JOB_GYRO_PITCH,
    JOB_FUSE_ROLL,
    JOB_FUSE_PITCH
  } job_t;

  // Saturate a wide signed value to the state range.
  function automatic logic signed [ST_W-1:0] sat_st(input logic signed [SUM_W-1:0] v);
    if (v > ST_MAX) begin
      return ST_MAX;
    end else if (v < ST_MIN) begin
      return ST_MIN;
    end
    return v[ST_W-1:0];
  endfunction

  // Gyro-only output: estimate times fifty, truncated toward zero, saturated.
  function automatic angle_t gyro_to_cd(input logic signed [ST_W-1:0] est);
    logic [ST_W-1:0] mag;
    logic [ST_W+5:0] prod;
    logic [ST_W+5:0] v;
    angle_t          res;
    mag  = est[ST_W-1] ? ST_W'(-est) : est;
    prod = (ST_W+6)'(mag) * (ST_W+6)'(GYRO_OUT_SCALE);
    v    = prod >> FRAC_BITS;
    if (est[ST_W-1]) begin
      res = (v > SAT_NEG_MAG) ? 16'sh8000 : -16'(v);
    end else begin
      res = (v > SAT_POS_MAG) ? 16'sh7fff : 16'(v);
    end
    return res;
  endfunction

  state_t state_r, state_nxt;
  job_t   job_r;

  logic [7:0] lpf_divisor_r;
  logic [6:0] cf_weight_r;

  // Latched item.
  ticks_t  period_r;
  sample_t ar_r, ap_r, av_r, gr_r, gp_r;
  logic [20:0] rsq_r, psq_r, vsq_r;

  // Filter state.
  logic signed [ST_W-1:0] roll_est_r, pitch_est_r, s_roll_r, s_pitch_r;

  // Shared multiplier and divider.
  logic signed [ST_W+16:0] mul_r;
  logic [DIVW-1:0]         quo_r;
  logic [DVR_W-1:0]        rem_r, dvr_r;
  logic                    neg_r;
  logic [CNT_W-1:0]        step_r;

  // Square root and CORDIC.
  logic [63:0]          sq_num_r, sq_root_r;
  logic signed [CW-1:0] cx_r, cy_r;
  logic signed [31:0]   cz_r;
  logic                 a_neg_r, a_zero_r, ang_roll_r;

  // Results and the output register.
  logic   trusted_r;
  angle_t res_roll_r, res_pitch_r;
  logic   out_valid_r, out_trusted_r;
  angle_t out_roll_r, out_pitch_r;

  // Combinational helpers.
  logic signed [21:0]      ar_sq, ap_sq, av_sq;
  logic [21:0]             mag_sum;
  logic                    mag_ok;
  logic                    job_pitch, lpf_on;
  logic [10:0]             fuse_w;
  logic signed [ST_W-1:0]  s_sel, est_job, mul_a;
  logic signed [16:0]      mul_b;
  sample_t                 acc_sel, gyr_sel;
  logic signed [NUM_W-1:0] acc_fix, num;
  logic [NUM_W-1:0]        num_abs;
  logic [DVR_W-1:0]        dvr_sel;
  logic [DVR_W:0]          trial;
  logic                    ge;
  logic signed [SUM_W-1:0] q_s, est_sum;
  logic [63:0]             sq_bit, sq_sum, root_new;
  logic                    sq_take;
  logic [4:0]              cidx;
  logic signed [ST_W-1:0]  est_ang;
  logic [ST_W-1:0]         est_abs;
  logic [AW-1:0]           a_val;
  logic [21:0]             sumsq;
  logic signed [CW-1:0]    sx, sy;
  logic [30:0]             z_clamp;
  logic [59:0]             cd_prod;
  logic [13:0]             cd_raw, cd;
  angle_t                  ang_val, roll_fold;

  assign in_chan.ready          = (state_r == S_IDLE);
  assign cfg_chan.ready         = 1'b1;
  assign out_chan.valid         = out_valid_r;
  assign out_chan.roll_angle    = out_roll_r;
  assign out_chan.pitch_angle   = out_pitch_r;
  assign out_chan.accel_trusted = out_trusted_r;

  // Squares and the magnitude window.
  assign ar_sq   = ar_r * ar_r;
  assign ap_sq   = ap_r * ap_r;
  assign av_sq   = av_r * av_r;
  assign mag_sum = 22'(rsq_r) + 22'(psq_r) + 22'(vsq_r);
  assign mag_ok  = (mag_sum > MAG_LOW) && (mag_sum < MAG_HIGH);

  // Operand selection for the current division job.
  assign job_pitch = (job_r == JOB_LPF_PITCH) || (job_r == JOB_GYRO_PITCH) ||
                     (job_r == JOB_FUSE_PITCH);
  assign lpf_on    = lpf_divisor_r > 8'd1;
  assign fuse_w    = 11'(cf_weight_r) * 11'd10;
  assign s_sel     = job_pitch ? s_pitch_r : s_roll_r;
  assign est_job   = job_pitch ? pitch_est_r : roll_est_r;
  assign acc_sel   = job_pitch ? ap_r : ar_r;
  assign gyr_sel   = job_pitch ? gp_r : gr_r;
  assign acc_fix   = NUM_W'(acc_sel) <<< FRAC_BITS;

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    num     = '0;
    dvr_sel = DVR_W'(1);
    case (job_r) inside
      JOB_LPF_ROLL, JOB_LPF_PITCH: begin
        mul_a   = s_sel;
        mul_b   = $signed({9'b0, lpf_divisor_r}) - 17'sd1;
        num     = lpf_on ? NUM_W'(mul_r) - acc_fix : acc_fix;
        dvr_sel = lpf_on ? DVR_W'(lpf_divisor_r) : DVR_W'(1);
      end
      JOB_GYRO_ROLL, JOB_GYRO_PITCH: begin
        mul_a   = ST_W'(gyr_sel);
        mul_b   = $signed({1'b0, period_r});
        num     = NUM_W'(mul_r) <<< FRAC_BITS;
        dvr_sel = TICK_DIV;
      end
      JOB_FUSE_ROLL, JOB_FUSE_PITCH: begin
        mul_a   = est_job;
        mul_b   = $signed({6'b0, fuse_w});
        num     = NUM_W'(mul_r) - NUM_W'(s_sel);
        dvr_sel = DVR_W'(fuse_w) + DVR_W'(1);
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  assign num_abs = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);

  // One restoring divider step.
  assign trial = {rem_r, quo_r[DIVW-1]};
  assign ge    = trial >= {1'b0, dvr_r};

  // Signed quotient and the gyro sum.
  assign q_s     = neg_r ? -$signed({2'b00, quo_r}) : $signed({2'b00, quo_r});
  assign est_sum = SUM_W'(est_job) + q_s;

  // One integer square root step.
  assign sq_bit   = 64'd1 << {step_r[4:0], 1'b0};
  assign sq_sum   = sq_root_r + sq_bit;
  assign sq_take  = sq_num_r >= sq_sum;
  assign root_new = sq_take ? (sq_root_r >> 1) + sq_bit : sq_root_r >> 1;

  // Angle set-up.
  assign est_ang = ang_roll_r ? roll_est_r : pitch_est_r;
  assign est_abs = est_ang[ST_W-1] ? ST_W'(-est_ang) : est_ang;
  assign a_val   = (AW'(est_abs) >> DOWN) << UP;
  assign sumsq   = ang_roll_r ? 22'(psq_r) + 22'(vsq_r) : 22'(rsq_r) + 22'(vsq_r);

  // One CORDIC vectoring step.
  assign cidx = step_r[4:0];
  assign sx   = cx_r >>> cidx;
  assign sy   = cy_r >>> cidx;

  // Angle scaling to 0.01 degree and the inverted fold of roll.
  assign z_clamp = (cz_r < 0) ? 31'd0 :
                   (cz_r > $signed({1'b0, HALF_PI_Q30})) ? HALF_PI_Q30 : cz_r[30:0];
  assign cd_prod = 60'(z_clamp) * 60'(CD_PER_RAD_Q16);
  assign cd_raw  = cd_prod[59:46];
  assign cd      = (cd_raw > QUARTER_TURN_CD) ? QUARTER_TURN_CD : cd_raw;
  assign ang_val = a_zero_r ? 16'sd0 : (a_neg_r ? -16'(cd) : 16'(cd));

  always_comb begin
    roll_fold = ang_val;
    if (av_r < 0) begin
      roll_fold = (ar_r > 0) ? HALF_TURN_CD - ang_val : -HALF_TURN_CD - ang_val;
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (in_chan.valid) state_nxt = S_SQUARE;
      S_SQUARE:   state_nxt = S_MUL;
      S_MUL:      state_nxt = S_PREP;
      S_PREP:     state_nxt = S_DIV;
      S_DIV:      if (step_r == '0) state_nxt = S_WB;
      S_WB: begin
        if (job_r == JOB_GYRO_PITCH) begin
          state_nxt = S_WRAP;
        end else if (job_r == JOB_FUSE_PITCH) begin
          state_nxt = S_ANG_INIT;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_WRAP:     state_nxt = mag_ok ? S_FLIP : S_GYRO_OUT;
      S_FLIP:     state_nxt = S_MUL;
      S_ANG_INIT: state_nxt = S_SQRT;
      S_SQRT:     if (step_r == '0) state_nxt = S_CORDIC;
      S_CORDIC:   if (cidx == 5'(CORDIC_STEPS - 1)) state_nxt = S_ANGLE;
      S_ANGLE:    state_nxt = ang_roll_r ? S_DONE : S_ANG_INIT;
      S_GYRO_OUT: state_nxt = S_DONE;
      S_DONE:     if (!out_valid_r || out_chan.ready) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      job_r         <= JOB_LPF_ROLL;
      lpf_divisor_r <= LPF_DIVISOR_RST;
      cf_weight_r   <= CF_WEIGHT_RST;
      roll_est_r    <= '0;
      pitch_est_r   <= '0;
      s_roll_r      <= '0;
      s_pitch_r     <= '0;
      trusted_r     <= 1'b0;
      ang_roll_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // Register writes.
      if (cfg_chan.valid) begin
        unique case (cfg_chan.index)
          REG_LPF_DIVISOR: lpf_divisor_r <= cfg_chan.data;
          REG_CF_WEIGHT:   cf_weight_r   <= cfg_chan.data[6:0];
          default: ;
        endcase
      end

      // The output register takes a finished item and empties when it is read.
      if ((state_r == S_DONE) && (!out_valid_r || out_chan.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_chan.ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_chan.valid) begin
            period_r <= in_chan.restart ? '0 : in_chan.period_ticks;
            ar_r     <= in_chan.accel_roll;
            ap_r     <= in_chan.accel_pitch;
            av_r     <= in_chan.accel_vertical;
            gr_r     <= in_chan.gyro_roll;
            gp_r     <= in_chan.gyro_pitch;
            if (in_chan.restart) begin
              roll_est_r  <= '0;
              pitch_est_r <= '0;
              s_roll_r    <= '0;
              s_pitch_r   <= '0;
            end
          end
        end
        S_SQUARE: begin
          rsq_r <= ar_sq[20:0];
          psq_r <= ap_sq[20:0];
          vsq_r <= av_sq[20:0];
          job_r <= JOB_LPF_ROLL;
        end
        S_MUL: begin
          mul_r <= mul_a * mul_b;
        end
        S_PREP: begin
          neg_r  <= num[NUM_W-1];
          quo_r  <= num_abs[DIVW-1:0];
          rem_r  <= '0;
          dvr_r  <= dvr_sel;
          step_r <= CNT_W'(DIVW - 1);
        end
        S_DIV: begin
          rem_r  <= ge ? DVR_W'(trial - {1'b0, dvr_r}) : trial[DVR_W-1:0];
          quo_r  <= {quo_r[DIVW-2:0], ge};
          step_r <= step_r - CNT_W'(1);
        end
        S_WB: begin
          unique case (job_r)
            JOB_LPF_ROLL: begin
              s_roll_r <= sat_st(q_s);
              job_r    <= JOB_LPF_PITCH;
            end
            JOB_LPF_PITCH: begin
              s_pitch_r <= sat_st(q_s);
              job_r     <= JOB_GYRO_ROLL;
            end
            JOB_GYRO_ROLL: begin
              roll_est_r <= sat_st(est_sum);
              job_r      <= JOB_GYRO_PITCH;
            end
            JOB_GYRO_PITCH: begin
              pitch_est_r <= sat_st(est_sum);
            end
            JOB_FUSE_ROLL: begin
              roll_est_r <= sat_st(q_s);
              job_r      <= JOB_FUSE_PITCH;
            end
            JOB_FUSE_PITCH: begin
              pitch_est_r <= sat_st(q_s);
              ang_roll_r  <= 1'b0;
            end
            default: ;
          endcase
        end
        S_WRAP: begin
          // Roll wraps with hysteresis, then the magnitude window decides fusion.
          if (64'(roll_est_r) > WRAP_HI_FIX) begin
            roll_est_r <= WRAP_NEG_FIX[ST_W-1:0];
          end else if (64'(roll_est_r) < WRAP_LO_FIX) begin
            roll_est_r <= WRAP_POS_FIX[ST_W-1:0];
          end
          trusted_r <= mag_ok;
        end
        S_FLIP: begin
          // Upside down: the smoothed accelerometer terms change sign.
          if (av_r < 0) begin
            s_roll_r  <= sat_st(-SUM_W'(s_roll_r));
            s_pitch_r <= sat_st(-SUM_W'(s_pitch_r));
          end
          job_r <= JOB_FUSE_ROLL;
        end
        S_ANG_INIT: begin
          a_neg_r   <= est_ang[ST_W-1];
          a_zero_r  <= (a_val == '0);
          cy_r      <= CW'(a_val);
          cz_r      <= '0;
          sq_num_r  <= 64'({sumsq, {SQ_SHIFT{1'b0}}});
          sq_root_r <= '0;
          step_r    <= CNT_W'(SQRT_STEPS - 1);
        end
        S_SQRT: begin
          if (sq_take) begin
            sq_num_r <= sq_num_r - sq_sum;
          end
          sq_root_r <= root_new;
          if (step_r == '0) begin
            cx_r <= CW'(root_new);
          end else begin
            step_r <= step_r - CNT_W'(1);
          end
        end
        S_CORDIC: begin
          // Rotate towards the x axis and accumulate the angle.
          if (cy_r > 0) begin
            cx_r <= cx_r + sy;
            cy_r <= cy_r - sx;
            cz_r <= cz_r + $signed({2'b00, ATAN_Q30[cidx]});
          end else begin
            cx_r <= cx_r - sy;
            cy_r <= cy_r + sx;
            cz_r <= cz_r - $signed({2'b00, ATAN_Q30[cidx]});
          end
          step_r <= step_r + CNT_W'(1);
        end
        S_ANGLE: begin
          if (ang_roll_r) begin
            res_roll_r <= roll_fold;
          end else begin
            res_pitch_r <= ang_val;
            ang_roll_r  <= 1'b1;
          end
        end
        S_GYRO_OUT: begin
          res_roll_r  <= gyro_to_cd(roll_est_r);
          res_pitch_r <= gyro_to_cd(pitch_est_r);
        end
        S_DONE: begin
          if (!out_valid_r || out_chan.ready) begin
            out_roll_r    <= res_roll_r;
            out_pitch_r   <= res_pitch_r;
            out_trusted_r <= trusted_r;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // An accepted item always starts the sequencer.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> (state_r != S_IDLE))
    else $error("sequencer did not leave idle after an item");

  // The divider remainder stays below the divisor.
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < dvr_r))
    else $error("divider remainder not below divisor");

  // Fusion divisions run only for trusted items.
  a_fuse_only_trusted: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_PREP) && ((job_r == JOB_FUSE_ROLL) || (job_r == JOB_FUSE_PITCH)))
    |-> trusted_r)
    else $error("fusion started on an untrusted item");

  // A fused pitch never exceeds a quarter turn.
  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_trusted_r) |-> ((out_pitch_r <= 16'sd9000) &&
                                        (out_pitch_r >= -16'sd9000)))
    else $error("fused pitch out of range");
`endif

endmodule

/* tb/sv/cae_attitude_checker.sv */
// Checker of the attitude estimator: watches the channels, predicts each attitude item, compares.
`timescale 1ns / 100ps

module cae_attitude_checker import cae_pkg::*; #(
  parameter int FRAC_BITS = 32
) (
  input  logic clk,
  input  logic rst_n,
  cae_in_if    in_mon,
  cae_out_if   out_mon,
  cae_cfg_if   cfg_mon,
  output int   error_count,
  output int   attitude_pending
);

  typedef struct packed {
    angle_t roll;
    angle_t pitch;
    logic   trusted;
  } attitude_t;

  localparam longint EST_MAX = 64'sh7FFF_FFFF_FFFF;
  localparam longint EST_MIN = -EST_MAX - 1;
  localparam longint ONE_FIX = 64'sd1 <<< FRAC_BITS;
  localparam longint TICKS_PER_SEC = 1000000;

  attitude_t attitude_q[$];

  // Shadow of the block's state and registers.
  longint roll_est, pitch_est, accel_roll_lp, accel_pitch_lp;
  int     lpf_div, gyro_weight;

  function automatic longint clamp48(longint v);
    if (v > EST_MAX) return EST_MAX;
    if (v < EST_MIN) return EST_MIN;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= r + bitv) begin
        n = n - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return r;
  endfunction

  // Gyro rate times period, scaled to fixed point and truncated toward zero.
  function automatic longint rate_step(longint rate, longint ticks);
    longint prod, d;
    longint unsigned m, q, r;
    prod = rate * ticks;
    m = (prod < 0) ? -prod : prod;
    q = m / TICKS_PER_SEC;
    r = m % TICKS_PER_SEC;
    d = (q << FRAC_BITS) + ((r << FRAC_BITS) / TICKS_PER_SEC);
    return (prod < 0) ? -d : d;
  endfunction

  function automatic longint smooth(longint s, longint a);
    longint d;
    d = lpf_div;
    if (d > 1) return clamp48((s * (d - 1) - a * ONE_FIX) / d);
    return clamp48(a * ONE_FIX);
  endfunction

  // Angle in 0.01 degree by vectoring CORDIC on |est| over sqrt(sumsq).
  function automatic int tilt_cd(longint est, longint unsigned sumsq);
    logic neg;
    longint unsigned mag, zu, cd;
    longint x, y, z, nx;
    neg = est < 0;
    mag = neg ? -est : est;
    if (FRAC_BITS >= ANGLE_FRAC) mag = mag >> (FRAC_BITS - ANGLE_FRAC);
    else mag = mag << (ANGLE_FRAC - FRAC_BITS);
    if (mag == 0) return 0;
    x = int_sqrt(sumsq << SQ_SHIFT);
    y = mag;
    z = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + longint'(ATAN_Q30[i]);
      end else begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - longint'(ATAN_Q30[i]);
      end
      x = nx;
    end
    if (z < 0) z = 0;
    if (z > longint'(HALF_PI_Q30)) z = longint'(HALF_PI_Q30);
    zu = z;
    cd = (zu * 64'(CD_PER_RAD_Q16)) >> 46;
    if (cd > 9000) cd = 9000;
    return neg ? -int'(cd) : int'(cd);
  endfunction

  // Gyro-only angle: estimate times 50, saturated to 16 bits.
  function automatic int gyro_angle(longint est);
    longint unsigned m, v;
    m = (est < 0) ? -est : est;
    v = (m * 50) >> FRAC_BITS;
    if (est < 0) return (v > SAT_NEG_MAG) ? -SAT_NEG_MAG : -int'(v);
    return (v > SAT_POS_MAG) ? SAT_POS_MAG : int'(v);
  endfunction

  // Advance the shadow state by one sensor item and return the attitude it yields.
  function automatic attitude_t estimate_attitude(logic restart, ticks_t period,
      sample_t a_r, sample_t a_p, sample_t a_v, sample_t g_r, sample_t g_p);
    attitude_t res;
    longint ar, ap, av, ticks, w;
    longint unsigned rsq, psq, vsq, mag;
    int roll, pitch;
    ar = a_r;
    ap = a_p;
    av = a_v;
    ticks = period;
    rsq = ar * ar;
    psq = ap * ap;
    vsq = av * av;
    mag = rsq + psq + vsq;
    if (restart) begin
      roll_est = 0;
      pitch_est = 0;
      accel_roll_lp = 0;
      accel_pitch_lp = 0;
      ticks = 0;
    end
    accel_roll_lp = smooth(accel_roll_lp, ar);
    accel_pitch_lp = smooth(accel_pitch_lp, ap);
    roll_est = clamp48(roll_est + rate_step(longint'(g_r), ticks));
    pitch_est = clamp48(pitch_est + rate_step(longint'(g_p), ticks));
    // Roll wraps with hysteresis.
    if (roll_est > WRAP_HIGH * ONE_FIX) roll_est = WRAP_TO_NEG * ONE_FIX;
    if (roll_est < WRAP_LOW * ONE_FIX) roll_est = WRAP_TO_POS * ONE_FIX;
    if (mag > longint'(MAG_LOW) && mag < longint'(MAG_HIGH)) begin
      w = gyro_weight * 10;
      if (av < 0) begin
        accel_roll_lp = clamp48(-accel_roll_lp);
        accel_pitch_lp = clamp48(-accel_pitch_lp);
      end
      roll_est = clamp48((roll_est * w - accel_roll_lp) / (w + 1));
      pitch_est = clamp48((pitch_est * w - accel_pitch_lp) / (w + 1));
      pitch = tilt_cd(pitch_est, rsq + vsq);
      roll = tilt_cd(roll_est, psq + vsq);
      // Upside down, roll folds about the half turn.
      if (av < 0) begin
        if (ar > 0) roll = int'(HALF_TURN_CD) - roll;
        else roll = -int'(HALF_TURN_CD) - roll;
      end
      res.trusted = 1'b1;
    end else begin
      roll = gyro_angle(roll_est);
      pitch = gyro_angle(pitch_est);
      res.trusted = 1'b0;
    end
    res.roll = angle_t'(roll);
    res.pitch = angle_t'(pitch);
    return res;
  endfunction

  assign attitude_pending = attitude_q.size();

  // Track register writes, predict on input items and check result items.
  always @(posedge clk) begin
    attitude_t want;
    if (!rst_n) begin
      roll_est <= 0;
      pitch_est <= 0;
      accel_roll_lp <= 0;
      accel_pitch_lp <= 0;
      lpf_div <= LPF_DIVISOR_RST;
      gyro_weight <= CF_WEIGHT_RST;
      error_count <= 0;
      attitude_q.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.index == REG_LPF_DIVISOR) lpf_div = cfg_mon.data;
        else if (cfg_mon.index == REG_CF_WEIGHT) gyro_weight = cfg_mon.data[6:0];
      end
      if (in_mon.valid && in_mon.ready) begin
        attitude_q.push_back(estimate_attitude(in_mon.restart, in_mon.period_ticks,
            in_mon.accel_roll, in_mon.accel_pitch, in_mon.accel_vertical,
            in_mon.gyro_roll, in_mon.gyro_pitch));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (attitude_q.size() == 0) begin
          $display("%0t: unexpected item roll %0d pitch %0d trusted %0b", $time,
                   out_mon.roll_angle, out_mon.pitch_angle, out_mon.accel_trusted);
          error_count <= error_count + 1;
        end else begin
          want = attitude_q.pop_front();
          if (out_mon.roll_angle !== want.roll || out_mon.pitch_angle !== want.pitch ||
              out_mon.accel_trusted !== want.trusted) begin
            $display("%0t: mismatch expected roll %0d pitch %0d trusted %0b, got %0d %0d %0b",
                     $time, want.roll, want.pitch, want.trusted, out_mon.roll_angle,
                     out_mon.pitch_angle, out_mon.accel_trusted);
            error_count <= error_count + 1;
          end
        end
      end
    end
  end

endmodule

/* tb/sv/tb_complementary_attitude_estimator.sv */
// Testbench top of the attitude estimator: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 100ps

module tb_complementary_attitude_estimator import cae_pkg::*; ();

  localparam cfg_index_t CFG_SPARE_IDX = 2'd3;
  localparam int STALL_LIMIT = 30000;
  localparam int DRAIN_CYCLES = 600;

  logic clk;
  logic rst_n;
  int   error_count;
  int   attitude_pending;
  int   send_idle_pct;
  int   rcv_idle_pct;
  int   rcv_hold_cycles;
  int   quiet_cycles;

  cae_in_if  in_bus ();
  cae_out_if out_bus ();
  cae_cfg_if cfg_bus ();

  complementary_attitude_estimator dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus),
    .cfg_chan (cfg_bus)
  );

  cae_attitude_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_mon           (in_bus),
    .out_mon          (out_bus),
    .cfg_mon          (cfg_bus),
    .error_count      (error_count),
    .attitude_pending (attitude_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls, or a long hold-off while the sender keeps offering items.
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rcv_hold_cycles > 0) begin
        out_bus.ready = 1'b0;
        rcv_hold_cycles = rcv_hold_cycles - 1;
      end else begin
        out_bus.ready = ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // Watchdog on cycles with no handshake on any channel.
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Offer one sensor item and hold it until it is taken.
  task automatic send_sample(logic restart, ticks_t period, sample_t a_r, sample_t a_p,
                             sample_t a_v, sample_t g_r, sample_t g_p);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid = 1'b0;
      @(negedge clk);
    end
    in_bus.valid = 1'b1;
    in_bus.restart = restart;
    in_bus.period_ticks = period;
    in_bus.accel_roll = a_r;
    in_bus.accel_pitch = a_p;
    in_bus.accel_vertical = a_v;
    in_bus.gyro_roll = g_r;
    in_bus.gyro_pitch = g_p;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_bus.valid = 1'b0;
    while (attitude_pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, cfg_data_t value);
    @(negedge clk);
    cfg_bus.valid = 1'b1;
    cfg_bus.index = idx;
    cfg_bus.data = value;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  // Mostly near-1G accelerometer vectors with random sign, some fully random items.
  task automatic send_random_sample();
    sample_t a_r, a_p, a_v;
    ticks_t  period;
    logic    restart;
    restart = ($urandom_range(99) < 3);
    if ($urandom_range(99) < 65) begin
      a_v = sample_t'($urandom_range(140, 75));
      if ($urandom_range(3) == 0) a_v = -a_v;
      a_r = sample_t'(int'($urandom_range(160)) - 80);
      a_p = sample_t'(int'($urandom_range(160)) - 80);
    end else begin
      a_r = sample_t'($urandom);
      a_p = sample_t'($urandom);
      a_v = sample_t'($urandom);
    end
    period = ($urandom_range(9) == 0) ? ticks_t'($urandom) : ticks_t'($urandom_range(5000));
    send_sample(restart, period, a_r, a_p, a_v, sample_t'($urandom), sample_t'($urandom));
  endtask

  task automatic run_phase(cfg_data_t divisor, cfg_data_t weight, int count);
    wait_idle();
    write_reg(REG_LPF_DIVISOR, divisor);
    write_reg(REG_CF_WEIGHT, weight);
    repeat (count) send_random_sample();
  endtask

  initial begin
    rst_n = 1'b0;
    send_idle_pct = 6;
    rcv_idle_pct = 67;
    rcv_hold_cycles = 0;
    in_bus.valid = 1'b0;
    in_bus.restart = 1'b0;
    in_bus.period_ticks = '0;
    in_bus.accel_roll = '0;
    in_bus.accel_pitch = '0;
    in_bus.accel_vertical = '0;
    in_bus.gyro_roll = '0;
    in_bus.gyro_pitch = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = REG_LPF_DIVISOR;
    cfg_bus.data = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed items at the reset register values.
    send_sample(1'b1, 16'hFFFF, 11'sd0, 11'sd0, 11'sd120, 11'sd0, 11'sd0);
    send_sample(1'b0, 16'd0, 11'sd0, 11'sd0, 11'sd0, 11'sd0, 11'sd0);
    send_sample(1'b0, 16'hFFFF, -11'sd1024, -11'sd1024, -11'sd1024, 11'sd1023, 11'sd1023);
    send_sample(1'b0, 16'hFFFF, 11'sd1023, 11'sd1023, 11'sd1023, 11'sd1023, 11'sd1023);
    // Roll runs past the upper wrap, pitch towards output saturation.
    repeat (4) send_sample(1'b0, 16'hFFFF, 11'sd0, 11'sd0, 11'sd0, 11'sd1023, 11'sd1023);
    // Roll runs past the lower wrap.
    repeat (7) send_sample(1'b0, 16'hFFFF, 11'sd0, 11'sd0, 11'sd0, -11'sd1024, -11'sd1024);
    // Fused upright, and upside down with positive and non-positive roll accel.
    send_sample(1'b0, 16'd2500, 11'sd30, -11'sd20, 11'sd118, 11'sd40, -11'sd40);
    send_sample(1'b0, 16'd2500, 11'sd30, 11'sd20, -11'sd118, 11'sd40, -11'sd40);
    send_sample(1'b0, 16'd2500, -11'sd30, 11'sd20, -11'sd118, -11'sd40, 11'sd40);
    // Zero denominators: all gravity on one tilt axis.
    send_sample(1'b0, 16'd1000, 11'sd120, 11'sd0, 11'sd0, 11'sd10, 11'sd10);
    send_sample(1'b0, 16'd1000, 11'sd0, -11'sd120, 11'sd0, 11'sd10, 11'sd10);
    // Zero estimate after a restart.
    send_sample(1'b1, 16'd1000, 11'sd0, 11'sd120, 11'sd0, 11'sd0, 11'sd0);
    // Magnitude right at the window edges: 11289 and 20664 are excluded.
    send_sample(1'b0, 16'd100, 11'sd7, 11'sd2, -11'sd106, 11'sd0, 11'sd0);
    send_sample(1'b0, 16'd100, 11'sd20, 11'sd10, 11'sd142, 11'sd0, 11'sd0);

    // An unknown index and a weight byte with its spare top bit set.
    wait_idle();
    write_reg(CFG_SPARE_IDX, 8'hFF);
    write_reg(REG_CF_WEIGHT, 8'hE4);
    repeat (10) send_random_sample();

    // Sender seldom idle, receiver often stalling.
    run_phase(8'd0, 8'd0, 130);
    run_phase(8'd1, 8'd100, 130);
    run_phase(8'd255, 8'd1, 130);
    run_phase(8'd2, 8'd50, 130);

    // Sender often idle, receiver seldom stalling.
    send_idle_pct = 67;
    rcv_idle_pct = 6;
    run_phase(8'd255, 8'd100, 130);
    run_phase(8'd3, 8'd0, 130);
    run_phase(8'd16, 8'd7, 130);
    run_phase(8'd8, 8'd30, 130);

    // No idling, with one long receiver hold-off to back up the input.
    send_idle_pct = 0;
    rcv_idle_pct = 0;
    run_phase(8'd4, 8'd99, 20);
    rcv_hold_cycles = 3000;
    repeat (110) send_random_sample();
    run_phase(8'd0, 8'd100, 130);
    run_phase(8'd200, 8'd2, 130);
    run_phase(8'd8, 8'd30, 140);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/cae_pkg.sv
rtl/cae_if.sv
rtl/complementary_attitude_estimator.sv
tb/sv/cae_attitude_checker.sv
tb/sv/tb_complementary_attitude_estimator.sv
